FILE: src/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg: shared constants for the positional insert/delete array
// Sizes, command codes and status codes used by the array and its testbench.
// ----------------------------------------------------------------------------
package pia_pkg;

    // Storage size and derived widths
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Fixed field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 7;
    localparam int STAT_W = 2;
    localparam int IDX_W  = 6;
    localparam int CNT_W  = 7;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_END   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

endpackage

FILE: src/pia_ram.sv
// ----------------------------------------------------------------------------
// pia_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pia_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

FILE: src/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array: dense word array with positional edits
// Insert front/end/at position, delete at position and dump, over a RAM
// walked by a small sequencer with one shared pointer unit.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  command   in         start / busy        cmd, value, position
//  result    out        valid (strobe)      status, data, index, count, last
//
//  A command is taken when start is high and busy is low. Rejected commands,
//  unknown codes and a delete of the top entry are never busy; the next
//  command may follow straight away. An insert at the end only stores its
//  word; other inserts first move the entries at and above the slot up, a
//  delete moves those above its slot down, a dump reads out every entry
//  (one result per cycle); the RAM's single write and registered read port
//  move one entry per cycle. Reset clears only the control registers; slots
//  at or above the fill count are never read. Results cannot be stalled.
// ----------------------------------------------------------------------------
module positional_insert_delete_array
    import pia_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     valid,
    output logic [STAT_W-1:0]        status,
    output logic signed [DATA_W-1:0] data,
    output logic [IDX_W-1:0]         index,
    output logic [CNT_W-1:0]         count,
    output logic                     last
);

    // Sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              dump_reg, dump_next;
    logic              up_reg, up_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] wa_reg, wa_next;
    logic [DATA_W-1:0] val_reg, val_next;

    logic              valid_reg, valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [IDX_W-1:0]  index_reg, index_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              last_reg, last_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    logic              full;
    logic              pos_ok;
    logic [POS_W-1:0]  pos_m1;
    logic [CNT_W-1:0]  cnt_m1;
    logic [ADDR_W-1:0] pos_a;
    logic [ADDR_W-1:0] cnt_a;
    logic [ADDR_W-1:0] top_a;
    logic [ADDR_W-1:0] ins_a;
    logic [ADDR_W-1:0] ptr_inc;
    logic [ADDR_W-1:0] ptr_dec;

    // Entry store
    pia_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // Command decode helpers
    assign full    = (cnt_reg >= CNT_W'(CAPACITY));
    assign pos_ok  = (position != '0) && (position <= cnt_reg);
    assign pos_m1  = position - POS_W'(1);
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign pos_a   = pos_m1[ADDR_W-1:0];
    assign cnt_a   = cnt_reg[ADDR_W-1:0];
    assign top_a   = cnt_m1[ADDR_W-1:0];
    assign ptr_inc = ptr_reg + ADDR_W'(1);
    assign ptr_dec = ptr_reg - ADDR_W'(1);

    always_comb
    begin
        case (cmd)
            CMD_INS_FRONT: ins_a = '0;
            CMD_INS_END:   ins_a = cnt_a;
            default:       ins_a = pos_a;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dump_next   = dump_reg;
        up_next     = up_reg;
        pend_next   = pend_reg;
        ptr_next    = ptr_reg;
        end_next    = end_reg;
        wa_next     = wa_reg;
        val_next    = val_reg;

        valid_next  = 1'b0;
        status_next = status_reg;
        data_next   = data_reg;
        index_next  = index_reg;
        count_next  = count_reg;
        last_next   = last_reg;

        ram_we      = 1'b0;
        ram_waddr   = wa_reg;
        ram_wdata   = ram_rdata;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Single-result default; overridden by long commands
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    index_next  = '0;
                    count_next  = cnt_reg;
                    last_next   = 1'b1;
                    pend_next   = 1'b0;
                    case (cmd)
                        CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if ((cmd == CMD_INS_AT) && !pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                val_next   = value;
                                end_next   = ins_a;
                                dump_next  = 1'b0;
                                up_next    = 1'b1;
                                ptr_next   = top_a;
                                state_next = (ins_a == cnt_a) ? S_PUT : S_RUN;
                            end
                        end
                        CMD_DEL_AT:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (!pos_ok)
                            begin
                                status_next = ST_BADPOS;
                            end
                            else if (pos_a == top_a)
                            begin
                                // Top entry: nothing to move
                                cnt_next   = cnt_m1;
                                count_next = cnt_m1;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                dump_next  = 1'b0;
                                up_next    = 1'b0;
                                ptr_next   = pos_a + ADDR_W'(1);
                                end_next   = top_a;
                                state_next = S_RUN;
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                valid_next = 1'b0;
                                dump_next  = 1'b1;
                                up_next    = 1'b0;
                                ptr_next   = '0;
                                end_next   = top_a;
                                state_next = S_RUN;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end

            S_RUN:
            begin
                // Read at ptr; the word read last cycle lands now
                ram_we = pend_reg && !dump_reg;
                if (dump_reg && pend_reg)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    data_next   = ram_rdata;
                    index_next  = IDX_W'(wa_reg);
                    count_next  = cnt_reg;
                    last_next   = 1'b0;
                end
                pend_next = 1'b1;
                if (dump_reg)
                begin
                    wa_next = ptr_reg;
                end
                else if (up_reg)
                begin
                    wa_next = ptr_inc;
                end
                else
                begin
                    wa_next = ptr_dec;
                end
                if (ptr_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    ptr_next = up_reg ? ptr_dec : ptr_inc;
                end
            end

            S_DRAIN:
            begin
                // Final word in flight
                ram_we    = !dump_reg;
                pend_next = 1'b0;
                if (dump_reg)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    data_next   = ram_rdata;
                    index_next  = IDX_W'(wa_reg);
                    count_next  = cnt_reg;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (up_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cnt_next    = cnt_m1;
                    valid_next  = 1'b1;
                    status_next = ST_OK;
                    data_next   = '0;
                    index_next  = '0;
                    count_next  = cnt_m1;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            S_PUT:
            begin
                // Store the new word in the opened slot
                ram_we      = 1'b1;
                ram_waddr   = end_reg;
                ram_wdata   = val_reg;
                cnt_next    = cnt_reg + CNT_W'(1);
                valid_next  = 1'b1;
                status_next = ST_OK;
                data_next   = '0;
                index_next  = '0;
                count_next  = cnt_reg + CNT_W'(1);
                last_next   = 1'b1;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
            valid_reg <= valid_next;
        end
    end

    // Datapath and result registers
    always_ff @(posedge clk)
    begin
        dump_reg   <= dump_next;
        up_reg     <= up_next;
        ptr_reg    <= ptr_next;
        end_reg    <= end_next;
        wa_reg     <= wa_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        index_reg  <= index_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign valid  = valid_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign index  = index_reg;
    assign count  = count_reg;
    assign last   = last_reg;

endmodule

FILE: dv/positional_insert_delete_array_tb.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array_tb: self-checking bench for the word array
// Drives insert, delete, dump and spare command codes over the start/busy
// handshake, mirrors the array contents in a behavioural shadow copy and
// checks every strobed result, field by field, in order. A short directed
// table covers empty, bad-position and extreme-value cases. It is followed by
// random traffic that fills the array to capacity, drains it back to empty
// and then mixes all commands.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_tb
    import pia_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Spare command codes: the block must treat these as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int N_DIRECTED = 24;
    localparam int N_RANDOM   = 250;
    localparam int MAX_GAP    = 16;
    localparam int SETTLE     = 80;   // longer than a full dump

    typedef enum int {GROW, SHRINK, MIXED} traffic_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic [CNT_W-1:0]  count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  op;
        logic [DATA_W-1:0] word;
        logic [POS_W-1:0]  slot;
        logic              typed;
        logic [STAT_W-1:0] st;
        logic [CNT_W-1:0]  cnt;
    } dir_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic                     valid;
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         index;
    logic [CNT_W-1:0]         count;
    logic                     last;

    // Shadow copy of the array and the results still owed by the block
    logic [DATA_W-1:0] shadow_words [CAPACITY];
    int                shadow_fill;
    result_t           awaited_results [$];

    int  mismatches;
    int  results_checked;
    int  cmds_sent;
    int  dumps_sent;
    int  seen_full;
    int  seen_empty;
    int  seen_badpos;
    bit  no_gaps;

    dir_row_t dir_rows [N_DIRECTED];

    positional_insert_delete_array u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .value    (value),
        .position (position),
        .valid    (valid),
        .status   (status),
        .data     (data),
        .index    (index),
        .count    (count),
        .last     (last)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("[positional_insert_delete_array] ERROR");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatches < 30)
            $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // Queue one expected result; count is the shadow fill after the command
    task automatic owe_result(input logic [STAT_W-1:0] st, input logic [DATA_W-1:0] word,
                              input int idx, input logic is_last);
        result_t r;
        r.status = st;
        r.data   = word;
        r.index  = IDX_W'(idx);
        r.count  = CNT_W'(shadow_fill);
        r.last   = is_last;
        awaited_results.push_back(r);
        if (st == ST_FULL)   seen_full++;
        if (st == ST_EMPTY)  seen_empty++;
        if (st == ST_BADPOS) seen_badpos++;
    endtask

    // Shadow array update for one accepted transaction
    task automatic array_apply(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word,
                               input logic [POS_W-1:0] slot);
        int p;
        int hole;
        p = int'(slot);
        case (op)
            CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT:
            begin
                if (shadow_fill >= CAPACITY)
                    owe_result(ST_FULL, '0, 0, 1'b1);
                else if (op == CMD_INS_AT && (p < 1 || p > shadow_fill))
                    owe_result(ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    hole = (op == CMD_INS_FRONT) ? 0 :
                           (op == CMD_INS_END) ? shadow_fill : p - 1;
                    for (int i = shadow_fill; i > hole; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[hole] = word;
                    shadow_fill++;
                    owe_result(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_DEL_AT:
            begin
                if (shadow_fill == 0)
                    owe_result(ST_EMPTY, '0, 0, 1'b1);
                else if (p < 1 || p > shadow_fill)
                    owe_result(ST_BADPOS, '0, 0, 1'b1);
                else
                begin
                    for (int i = p - 1; i + 1 < shadow_fill; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_words[shadow_fill-1] = '0;
                    shadow_fill--;
                    owe_result(ST_OK, '0, 0, 1'b1);
                end
            end
            CMD_DUMP:
            begin
                dumps_sent++;
                if (shadow_fill == 0)
                    owe_result(ST_EMPTY, '0, 0, 1'b1);
                else
                    for (int i = 0; i < shadow_fill; i++)
                        owe_result(ST_OK, shadow_words[i], i, i + 1 == shadow_fill);
            end
            default:
                owe_result(ST_OK, '0, 0, 1'b1);
        endcase
    endtask

    // Present one command, hold it until taken, then predict its results.
    // A typed row replaces the predicted single result with the typed one.
    task automatic send_command(input dir_row_t row);
        int      gap;
        result_t fixed;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= row.op;
        value    <= row.word;
        position <= row.slot;
        @(posedge clk);
        while (busy) @(posedge clk);
        array_apply(row.op, row.word, row.slot);
        cmds_sent++;
        if (row.typed)
        begin
            fixed.status = row.st;
            fixed.data   = '0;
            fixed.index  = '0;
            fixed.count  = row.cnt;
            fixed.last   = 1'b1;
            void'(awaited_results.pop_back());
            awaited_results.push_back(fixed);
        end
    endtask

    function automatic dir_row_t mk_row(input logic [CMD_W-1:0] op, input logic [DATA_W-1:0] word,
                                        input logic [POS_W-1:0] slot, input logic typed,
                                        input logic [STAT_W-1:0] st, input int cnt);
        dir_row_t r;
        r.op    = op;
        r.word  = word;
        r.slot  = slot;
        r.typed = typed;
        r.st    = st;
        r.cnt   = CNT_W'(cnt);
        return r;
    endfunction

    function automatic logic [CMD_W-1:0] pick_op(input traffic_t mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            GROW:
                return (r < 30) ? CMD_INS_FRONT : (r < 55) ? CMD_INS_END :
                       (r < 85) ? CMD_INS_AT : (r < 92) ? CMD_DEL_AT :
                       (r < 97) ? CMD_DUMP : CMD_SPARE_5;
            SHRINK:
                return (r < 10) ? CMD_INS_AT : (r < 85) ? CMD_DEL_AT :
                       (r < 93) ? CMD_DUMP : (r < 97) ? CMD_INS_FRONT : CMD_SPARE_6;
            default:
                return (r < 18) ? CMD_INS_FRONT : (r < 36) ? CMD_INS_END :
                       (r < 56) ? CMD_INS_AT : (r < 80) ? CMD_DEL_AT :
                       (r < 94) ? CMD_DUMP : CMD_SPARE_7;
        endcase
    endfunction

    // Mostly valid positions, with wild, zero and one-past-the-top picks
    function automatic logic [POS_W-1:0] pick_slot();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0 || shadow_fill == 0)
            return POS_W'($urandom_range(0, 127));
        if (r == 1)
            return '0;
        if (r == 2)
            return POS_W'(shadow_fill + 1);
        return POS_W'($urandom_range(1, shadow_fill));
    endfunction

    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Result checker: each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && valid)
        begin
            if (awaited_results.size() == 0)
                flag_mismatch($sformatf("unexpected result status=%0d data=%h index=%0d count=%0d",
                                        status, data, index, count));
            else
            begin
                want = awaited_results.pop_front();
                results_checked++;
                if (status !== want.status)
                    flag_mismatch($sformatf("status got %0d want %0d", status, want.status));
                if (data !== want.data)
                    flag_mismatch($sformatf("data got %h want %h", data, want.data));
                if (index !== want.index)
                    flag_mismatch($sformatf("index got %0d want %0d", index, want.index));
                if (count !== want.count)
                    flag_mismatch($sformatf("count got %0d want %0d", count, want.count));
                if (last !== want.last)
                    flag_mismatch($sformatf("last got %0d want %0d", last, want.last));
            end
        end
    end

    // Stimulus
    initial
    begin
        traffic_t         mode;
        int               n;
        int               full_tries;
        int               empty_tries;
        dir_row_t         row;

        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= CMD_INS_FRONT;
        value       <= '0;
        position    <= '0;
        mismatches  = 0;
        results_checked = 0;
        cmds_sent   = 0;
        dumps_sent  = 0;
        seen_full   = 0;
        seen_empty  = 0;
        seen_badpos = 0;
        no_gaps     = 1'b0;
        shadow_fill = 0;
        for (int i = 0; i < CAPACITY; i++)
            shadow_words[i] = '0;

        // op, word, slot, typed, status, count after the command
        dir_rows = '{
            mk_row(CMD_DUMP,      '0,            7'd0,   1'b1, ST_EMPTY,  0),
            mk_row(CMD_DEL_AT,    '0,            7'd1,   1'b1, ST_EMPTY,  0),
            mk_row(CMD_INS_AT,    32'h1234_5678, 7'd1,   1'b1, ST_BADPOS, 0),
            mk_row(CMD_SPARE_5,   '1,            7'd1,   1'b1, ST_OK,     0),
            mk_row(CMD_INS_END,   32'h7FFF_FFFF, 7'd0,   1'b1, ST_OK,     1),
            mk_row(CMD_INS_FRONT, 32'h8000_0000, 7'd127, 1'b1, ST_OK,     2),
            mk_row(CMD_INS_AT,    '1,            7'd2,   1'b1, ST_OK,     3),
            mk_row(CMD_INS_AT,    32'h0F0F_0F0F, 7'd4,   1'b1, ST_BADPOS, 3),
            mk_row(CMD_INS_AT,    32'h0F0F_0F0F, 7'd0,   1'b1, ST_BADPOS, 3),
            mk_row(CMD_INS_AT,    32'h0F0F_0F0F, 7'd127, 1'b1, ST_BADPOS, 3),
            mk_row(CMD_DEL_AT,    '0,            7'd0,   1'b1, ST_BADPOS, 3),
            mk_row(CMD_DEL_AT,    '0,            7'd4,   1'b1, ST_BADPOS, 3),
            mk_row(CMD_DEL_AT,    '0,            7'd127, 1'b1, ST_BADPOS, 3),
            mk_row(CMD_SPARE_6,   '0,            7'd0,   1'b1, ST_OK,     3),
            mk_row(CMD_SPARE_7,   '1,            7'd127, 1'b1, ST_OK,     3),
            mk_row(CMD_DUMP,      '1,            7'd85,  1'b0, ST_OK,     0),
            mk_row(CMD_INS_AT,    32'h5555_AAAA, 7'd3,   1'b0, ST_OK,     0),
            mk_row(CMD_INS_AT,    '0,            7'd1,   1'b0, ST_OK,     0),
            mk_row(CMD_DUMP,      '0,            7'd42,  1'b0, ST_OK,     0),
            mk_row(CMD_DEL_AT,    '0,            7'd5,   1'b1, ST_OK,     4),
            mk_row(CMD_DEL_AT,    '0,            7'd1,   1'b1, ST_OK,     3),
            mk_row(CMD_DEL_AT,    '0,            7'd2,   1'b1, ST_OK,     2),
            mk_row(CMD_DUMP,      '0,            7'd0,   1'b0, ST_OK,     0),
            mk_row(CMD_INS_END,   32'h0000_0001, 7'd0,   1'b1, ST_OK,     3)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_rows[i])
            send_command(dir_rows[i]);

        // Random traffic: fill to capacity, drain to empty, then mix
        mode        = GROW;
        full_tries  = 0;
        empty_tries = 0;
        n           = 0;
        while (n < N_RANDOM)
        begin
            if (n % 16 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            row.op    = pick_op(mode);
            row.word  = pick_word();
            row.slot  = pick_slot();
            row.typed = 1'b0;
            row.st    = ST_OK;
            row.cnt   = '0;
            if (row.op <= CMD_DUMP)
                n++;
            if (mode == GROW && shadow_fill == CAPACITY && row.op <= CMD_INS_AT)
                full_tries++;
            if (mode == SHRINK && shadow_fill == 0 && row.op >= CMD_DEL_AT)
                empty_tries++;
            send_command(row);
            if (mode == GROW && full_tries >= 6)
                mode = SHRINK;
            else if (mode == SHRINK && empty_tries >= 4)
                mode = MIXED;
        end
        start <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("Sent %0d transactions (%0d directed, %0d dumps); %0d results checked.",
                 cmds_sent, N_DIRECTED, dumps_sent, results_checked);
        $display("Rejections predicted: %0d full, %0d empty, %0d bad position; %0d mismatches.",
                 seen_full, seen_empty, seen_badpos, mismatches);
        if (mismatches == 0)
            $display("[positional_insert_delete_array] OK");
        else
            $display("[positional_insert_delete_array] ERROR");
        $finish;
    end

endmodule

FILE: files.f
src/pia_pkg.sv
src/pia_ram.sv
src/positional_insert_delete_array.sv
dv/positional_insert_delete_array_tb.sv
